// ===== rtl/core/timecode_frame_count_converter_top_macros.svh =====
// Assertion macros shared by the timecode converter RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef TIMECODE_FRAME_COUNT_CONVERTER_TOP_MACROS_SVH
`define TIMECODE_FRAME_COUNT_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication.
`define TCC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcc: same-cycle check failed");

// Next-cycle implication.
`define TCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcc: next-cycle check failed");

`endif

// ===== rtl/core/tcc_pkg.sv =====
// Package for the timecode frame count converter: word types, status codes,
// register indexes and the derived rate constants shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int FC_W   = 37;
	localparam int RATE_W = 20;
	localparam int DPM_W  = 17;

	localparam logic [RATE_W-1:0] DROP_NUM_30 = 20'd30000;
	localparam logic [RATE_W-1:0] DROP_NUM_60 = 20'd60000;
	localparam logic [RATE_W-1:0] DROP_DEN    = 20'd1001;
	localparam logic [RATE_W-1:0] RESET_NUM   = 20'd30000;
	localparam logic [RATE_W-1:0] RESET_DEN   = 20'd1001;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_RATE_NUM = 2'd0;
	localparam logic [1:0] REG_RATE_DEN = 2'd1;
	localparam logic [1:0] REG_DROP     = 2'd2;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_BAD_RATE   = 4'd1;
	localparam logic [3:0] ST_BAD_DROP   = 4'd2;
	localparam logic [3:0] ST_HOUR_RANGE = 4'd3;
	localparam logic [3:0] ST_MIN_RANGE  = 4'd4;
	localparam logic [3:0] ST_SEC_RANGE  = 4'd5;
	localparam logic [3:0] ST_FRM_RANGE  = 4'd6;
	localparam logic [3:0] ST_DROPPED    = 4'd7;
	localparam logic [3:0] ST_CNT_RANGE  = 4'd8;

	typedef struct packed {
		logic              op;
		logic [FC_W-1:0]   frame_idx;
		logic [6:0]        hours;
		logic [6:0]        minutes;
		logic [6:0]        seconds;
		logic [RATE_W-1:0] frames;
	} in_word_t;

	typedef struct packed {
		logic [3:0]        status;
		logic [4:0]        out_hours;
		logic [5:0]        out_minutes;
		logic [5:0]        out_seconds;
		logic [RATE_W-1:0] out_frames;
		logic [FC_W-1:0]   out_frame_count;
	} out_word_t;

	typedef enum logic [2:0] {
		CFG_LOAD,
		CFG_DIV,
		CFG_ROUND,
		CFG_MUL1,
		CFG_MUL2,
		CFG_READY
	} cfg_state_t;

	// Constants derived from the rate registers.
	typedef struct packed {
		logic              busy;
		logic              drop;
		logic [3:0]        rate_st;
		logic [RATE_W-1:0] nom;
		logic [DPM_W-1:0]  dpm;
		logic [20:0]       dpm9;
		logic [25:0]       fpm;
		logic [25:0]       fpm_d;
		logic [31:0]       fph;
		logic [29:0]       fp10;
		logic [FC_W-1:0]   per_day;
	} derived_t;

	// Sideband carried alongside the division pipelines.
	typedef struct packed {
		logic              op;
		logic [3:0]        status;
		logic [FC_W-1:0]   fc;
		logic [10:0]       tm;
		logic [5:0]        sec;
		logic [RATE_W-1:0] fr;
		logic [16:0]       tms;
		logic [7:0]        tm10;
		logic [7:0]        blocks;
		logic [FC_W-1:0]   cnt;
		logic [4:0]        hrs;
		logic [5:0]        mins;
	} side_t;

endpackage

// ===== rtl/core/tcc_cfg.sv =====
// Rate registers and the sequencer that derives nominal rate and frame
// constants from them. Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [tcc_pkg::RATE_W-1:0] cfg_data,
	output tcc_pkg::derived_t          drv
);

	tcc_pkg::cfg_state_t state_q, state_d;

	logic [tcc_pkg::RATE_W-1:0] num_q, den_q;
	logic                       drop_q;
	logic [tcc_pkg::RATE_W-1:0] rem_q, nsh_q, quo_q, nom_q;
	logic [4:0]                 cnt_q;
	logic [tcc_pkg::DPM_W-1:0]  dpm_q;
	logic [20:0]                dpm9_q;
	logic [25:0]                fpm_q, fpm_d_q;
	logic [31:0]                fph_q;
	logic [29:0]                fp10_q;
	logic [tcc_pkg::FC_W-1:0]   nday_q, per_day_q;
	logic [3:0]                 rate_st_q;
	logic                       wr, busy;

	logic [20:0] trial, half;
	logic        ge, up;
	logic [40:0] recip;
	logic        drop_ok;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= tcc_pkg::RESET_NUM;
			den_q  <= tcc_pkg::RESET_DEN;
			drop_q <= 1'b0;
		end else if (wr) begin
			case (cfg_index)
				tcc_pkg::REG_RATE_NUM: num_q  <= cfg_data;
				tcc_pkg::REG_RATE_DEN: den_q  <= cfg_data;
				tcc_pkg::REG_DROP:     drop_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcc_pkg::CFG_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcc_pkg::CFG_LOAD:  state_d = tcc_pkg::CFG_DIV;
			tcc_pkg::CFG_DIV:   if (cnt_q == 5'd19) state_d = tcc_pkg::CFG_ROUND;
			tcc_pkg::CFG_ROUND: state_d = tcc_pkg::CFG_MUL1;
			tcc_pkg::CFG_MUL1:  state_d = tcc_pkg::CFG_MUL2;
			tcc_pkg::CFG_MUL2:  state_d = tcc_pkg::CFG_READY;
			tcc_pkg::CFG_READY: state_d = tcc_pkg::CFG_READY;
			default:            state_d = tcc_pkg::CFG_LOAD;
		endcase
		// Any register write starts the derivation again.
		if (wr) state_d = tcc_pkg::CFG_LOAD;
	end

	always_comb begin
		case (state_q)
			tcc_pkg::CFG_READY: busy = 1'b0;
			default:            busy = 1'b1;
		endcase
	end

	// One quotient bit per cycle of the restoring division num / den.
	assign trial = {rem_q, nsh_q[tcc_pkg::RATE_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign half  = ({1'b0, den_q} + 21'd1) >> 1;
	assign up    = {1'b0, rem_q} >= half;
	// Multiplying by 2^24/15 rounded up gives an exact nom/15 over 20 bits.
	assign recip = 41'(nom_q) * 41'd1118482;
	assign drop_ok = (den_q == tcc_pkg::DROP_DEN) &&
		(num_q == tcc_pkg::DROP_NUM_30 || num_q == tcc_pkg::DROP_NUM_60);

	always_ff @(posedge clk) begin
		case (state_q)
			tcc_pkg::CFG_LOAD: begin
				rem_q <= '0;
				nsh_q <= num_q;
				quo_q <= '0;
				cnt_q <= '0;
			end
			tcc_pkg::CFG_DIV: begin
				rem_q <= ge ? 20'(trial - {1'b0, den_q}) : trial[19:0];
				nsh_q <= {nsh_q[18:0], 1'b0};
				quo_q <= {quo_q[18:0], ge};
				cnt_q <= cnt_q + 5'd1;
			end
			tcc_pkg::CFG_ROUND: begin
				nom_q <= (den_q == '0) ? '0 : 20'(quo_q + {19'd0, up});
			end
			tcc_pkg::CFG_MUL1: begin
				dpm_q  <= recip[40:24];
				fpm_q  <= 26'(nom_q) * 26'd60;
				fph_q  <= 32'(nom_q) * 32'd3600;
				nday_q <= 37'(nom_q) * 37'd86400;
			end
			tcc_pkg::CFG_MUL2: begin
				fpm_d_q   <= fpm_q - 26'(dpm_q);
				fp10_q    <= 30'(fpm_q) * 30'd10 - 30'(dpm_q) * 30'd9;
				dpm9_q    <= 21'(dpm_q) * 21'd9;
				per_day_q <= drop_q ? nday_q - 37'(dpm_q) * 37'd1296 : nday_q;
				if (nom_q == '0) begin
					rate_st_q <= tcc_pkg::ST_BAD_RATE;
				end else if (drop_q && !drop_ok) begin
					rate_st_q <= tcc_pkg::ST_BAD_DROP;
				end else begin
					rate_st_q <= tcc_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign drv.busy    = busy;
	assign drv.drop    = drop_q;
	assign drv.rate_st = rate_st_q;
	assign drv.nom     = nom_q;
	assign drv.dpm     = dpm_q;
	assign drv.dpm9    = dpm9_q;
	assign drv.fpm     = fpm_q;
	assign drv.fpm_d   = fpm_d_q;
	assign drv.fph     = fph_q;
	assign drv.fp10    = fp10_q;
	assign drv.per_day = per_day_q;

endmodule

// ===== rtl/core/tcc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word travelling beside it. Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_div #(
	parameter int  QB     = 8,
	parameter type side_t = tcc_pkg::side_t
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  logic [tcc_pkg::FC_W-1:0] in_x,
	input  logic [tcc_pkg::FC_W-1:0] divisor,
	input  side_t                    in_side,
	output logic                     out_vld,
	output logic [QB-1:0]            out_q,
	output logic [tcc_pkg::FC_W-1:0] out_rem,
	output side_t                    out_side
);

	localparam int W  = tcc_pkg::FC_W;
	localparam int XW = W + QB;

	// The quotient must fit in QB bits; the caller guarantees that for
	// every word whose result is used.
	logic          vld_s  [QB+1];
	logic [W-1:0]  rem_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	side_t         side_s [QB+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_x;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int SH = QB - 1 - i;
		logic [XW-1:0] dsh;
		logic [QB:0]   qn;
		logic          ge;

		assign dsh = {{QB{1'b0}}, divisor} << SH;
		assign ge  = {{QB{1'b0}}, rem_s[i]} >= dsh;
		assign qn  = {quo_s[i], ge};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= ge ? rem_s[i] - dsh[W-1:0] : rem_s[i];
				quo_s[i+1]  <= qn[QB-1:0];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[QB];
	assign out_q    = quo_s[QB];
	assign out_rem  = rem_s[QB];
	assign out_side = side_s[QB];

endmodule

// ===== rtl/core/timecode_frame_count_converter_top.sv =====
// Top level of the timecode frame count converter: input checks, the chain
// of division pipelines and the output register.
// Depends on tcc_pkg, tcc_cfg, tcc_div and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage
// Input words (in_valid/in_ready, in_data) carry an op and either a frame
// count (op 0) or a label (op 1). Each word gives exactly one output word
// (out_valid/out_ready, out_data) holding a status and the converted value;
// value fields are zero whenever the status is not ok.
// The datapath is a 34-stage pipeline: an input check stage, five restoring
// dividers of 8, 4, 5, 6 and 6 stages, three arithmetic stages and the
// output register. One word is taken every cycle while in_ready is high.
// Rate registers are written through cfg_valid/cfg_index/cfg_data. After
// reset and after every write, a sequencer derives the nominal rate (a
// 20-step division) and the frame constants; in_ready is low while it
// runs.
// When the receiver stalls, the whole pipeline holds; in_ready falls in the
// same cycle, so no word is lost or repeated.
//

`include "timecode_frame_count_converter_top_macros.svh"

module timecode_frame_count_converter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tcc_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tcc_pkg::out_word_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [tcc_pkg::RATE_W-1:0] cfg_data
);

	localparam int W = tcc_pkg::FC_W;

	tcc_pkg::derived_t drv;
	logic              adv;

	tcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.drv       (drv)
	);

	// The whole pipeline moves together unless the output word is stuck.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv && !drv.busy;

	// ---------------------------------------------------------------- stage 1
	logic [3:0]      st_in;
	logic [14:0]     mx;
	logic [3:0]      m_div10;
	logic [6:0]      m_rem10;
	logic [10:0]     tm_in;
	tcc_pkg::side_t  side_in;
	logic            v_s1;
	tcc_pkg::side_t  side_s1;

	// minutes / 10 by reciprocal, exact well beyond seven bits.
	assign mx      = 15'(in_data.minutes) * 15'd205;
	assign m_div10 = mx[14:11];
	assign m_rem10 = in_data.minutes - 7'({3'd0, m_div10} * 7'd10);
	assign tm_in   = 11'(in_data.hours[4:0]) * 11'd60 + 11'(in_data.minutes[5:0]);

	always_comb begin
		if (drv.rate_st != tcc_pkg::ST_OK) begin
			st_in = drv.rate_st;
		end else if (!in_data.op) begin
			st_in = (in_data.frame_idx >= drv.per_day) ? tcc_pkg::ST_CNT_RANGE
				: tcc_pkg::ST_OK;
		end else if (in_data.hours >= 7'd24) begin
			st_in = tcc_pkg::ST_HOUR_RANGE;
		end else if (in_data.minutes >= 7'd60) begin
			st_in = tcc_pkg::ST_MIN_RANGE;
		end else if (in_data.seconds >= 7'd60) begin
			st_in = tcc_pkg::ST_SEC_RANGE;
		end else if (in_data.frames >= drv.nom) begin
			st_in = tcc_pkg::ST_FRM_RANGE;
		end else if (drv.drop && m_rem10 != 7'd0 && in_data.seconds == 7'd0 &&
			in_data.frames < {3'd0, drv.dpm}) begin
			st_in = tcc_pkg::ST_DROPPED;
		end else begin
			st_in = tcc_pkg::ST_OK;
		end
	end

	always_comb begin
		side_in        = '0;
		side_in.op     = in_data.op;
		side_in.status = st_in;
		side_in.fc     = in_data.frame_idx;
		side_in.tm     = tm_in;
		side_in.sec    = in_data.seconds[5:0];
		side_in.fr     = in_data.frames;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
		end
	end

	// ------------------------------------------- ten-minute blocks (drop only)
	logic            va;
	logic [7:0]      qa;
	logic [W-1:0]    ra;
	tcc_pkg::side_t  sa;

	tcc_div #(.QB(8)) u_div_blk (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s1),
		.in_x     (side_s1.fc),
		.divisor  (W'(drv.fp10)),
		.in_side  (side_s1),
		.out_vld  (va),
		.out_q    (qa),
		.out_rem  (ra),
		.out_side (sa)
	);

	// ---------------------------------------------------------------- stage 2
	logic            v_s2;
	logic [W-1:0]    remd_s2;
	tcc_pkg::side_t  side_s2;
	tcc_pkg::side_t  side_s2_d;
	logic [23:0]     tm_x;

	assign tm_x = 24'(sa.tm) * 24'd6554;

	always_comb begin
		side_s2_d        = sa;
		side_s2_d.blocks = qa;
		side_s2_d.tms    = 17'(sa.tm) * 17'd60 + 17'(sa.sec);
		side_s2_d.tm10   = tm_x[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			remd_s2 <= (ra > W'(drv.dpm)) ? ra - W'(drv.dpm) : '0;
			side_s2 <= side_s2_d;
		end
	end

	// ---------------------------------- minutes past the block (drop only)
	logic            vb;
	logic [3:0]      qb;
	logic [W-1:0]    rb;
	tcc_pkg::side_t  sb;

	tcc_div #(.QB(4)) u_div_min10 (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s2),
		.in_x     (remd_s2),
		.divisor  (W'(drv.fpm_d)),
		.in_side  (side_s2),
		.out_vld  (vb),
		.out_q    (qb),
		.out_rem  (rb),
		.out_side (sb)
	);

	// ---------------------------------------------------------------- stage 3
	logic            v_s3;
	tcc_pkg::side_t  side_s3;
	logic [28:0]     add9_s3;
	logic [20:0]     addk_s3;
	logic [W-1:0]    prod_s3;
	logic [27:0]     pd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= sb;
			add9_s3 <= 29'(drv.dpm9) * 29'(sb.blocks);
			addk_s3 <= 21'(drv.dpm) * 21'(qb);
			prod_s3 <= W'(sb.tms) * W'(drv.nom);
			pd_s3   <= 28'(drv.dpm) * 28'(sb.tm - 11'(sb.tm10));
		end
	end

	// ---------------------------------------------------------------- stage 4
	logic            v_s4;
	logic [W-1:0]    lab_s4;
	tcc_pkg::side_t  side_s4;
	tcc_pkg::side_t  side_s4_d;

	always_comb begin
		side_s4_d     = side_s3;
		side_s4_d.cnt = prod_s3 + W'(side_s3.fr) - (drv.drop ? W'(pd_s3) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	// Skipped labels are added back to the count to get a plain label index.
	always_ff @(posedge clk) begin
		if (adv) begin
			lab_s4  <= drv.drop ? side_s3.fc + W'(add9_s3) + W'(addk_s3) : side_s3.fc;
			side_s4 <= side_s4_d;
		end
	end

	// -------------------------------------------------- hours, minutes, seconds
	logic            vc, vd, ve;
	logic [4:0]      qc;
	logic [5:0]      qd, qe;
	logic [W-1:0]    rc, rd, re;
	tcc_pkg::side_t  sc, sd, se, sc_h, sd_m;

	tcc_div #(.QB(5)) u_div_hrs (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s4),
		.in_x     (lab_s4),
		.divisor  (W'(drv.fph)),
		.in_side  (side_s4),
		.out_vld  (vc),
		.out_q    (qc),
		.out_rem  (rc),
		.out_side (sc)
	);

	always_comb begin
		sc_h     = sc;
		sc_h.hrs = qc;
	end

	tcc_div #(.QB(6)) u_div_mins (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vc),
		.in_x     (rc),
		.divisor  (W'(drv.fpm)),
		.in_side  (sc_h),
		.out_vld  (vd),
		.out_q    (qd),
		.out_rem  (rd),
		.out_side (sd)
	);

	always_comb begin
		sd_m      = sd;
		sd_m.mins = qd;
	end

	tcc_div #(.QB(6)) u_div_secs (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vd),
		.in_x     (rd),
		.divisor  (W'(drv.nom)),
		.in_side  (sd_m),
		.out_vld  (ve),
		.out_q    (qe),
		.out_rem  (re),
		.out_side (se)
	);

	// -------------------------------------------------------- output register
	tcc_pkg::out_word_t out_d;

	always_comb begin
		out_d        = '0;
		out_d.status = se.status;
		if (se.status == tcc_pkg::ST_OK) begin
			if (!se.op) begin
				out_d.out_hours   = se.hrs;
				out_d.out_minutes = se.mins;
				out_d.out_seconds = qe;
				out_d.out_frames  = re[tcc_pkg::RATE_W-1:0];
			end else begin
				out_d.out_frame_count = se.cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ve;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= out_d;
		end
	end

	// --------------------------------------------------------------- checks
	logic chk_ok, chk_zero, chk_label, chk_frame;

	assign chk_ok    = out_valid && out_data.status == tcc_pkg::ST_OK;
	assign chk_zero  = {out_data.out_hours, out_data.out_minutes, out_data.out_seconds,
		out_data.out_frames, out_data.out_frame_count} == '0;
	assign chk_label = out_data.out_hours < 5'd24 && out_data.out_minutes < 6'd60 &&
		out_data.out_seconds < 6'd60;
	assign chk_frame = out_data.out_frames < drv.nom;

	`TCC_ASSERT_IMPL(a_err_zero, out_valid && !chk_ok, chk_zero)
	`TCC_ASSERT_IMPL(a_label_range, chk_ok, chk_label)
	`TCC_ASSERT_IMPL(a_frame_below_nom, chk_ok && !drv.busy, chk_frame)
	`TCC_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !in_ready)

endmodule

// ===== verif/timecode_frame_count_converter_top_tb.sv =====
// Testbench for the timecode frame count converter top level.
// Drives directed and random conversions under several rate settings and checks each output
// word against a typed-in expected word or an in-bench timecode predictor. Depends on tcc_pkg and the RTL.
`timescale 1ns / 1ps

module timecode_frame_count_converter_top_tb;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int LATENCY = 34;
	localparam int IN_W = $bits(tcc_pkg::in_word_t);

	typedef struct {
		logic [19:0] num;
		logic [19:0] den;
		logic        drop;
	} rate_set_t;

	// One row of the directed table; known marks a typed-in expected word.
	typedef struct {
		tcc_pkg::in_word_t  word;
		logic               known;
		tcc_pkg::out_word_t want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	tcc_pkg::in_word_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	tcc_pkg::out_word_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = tcc_pkg::REG_RATE_NUM;
	logic [19:0]        cfg_data = '0;

	logic [63:0] rate_num = 64'd30000;
	logic [63:0] rate_den = 64'd1001;
	logic        drop_on = 1'b0;

	tcc_pkg::out_word_t pending_words[$];
	int                 mismatches = 0;
	int                 cycles = 0;
	int                 rx_hold = 0;

	timecode_frame_count_converter_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic logic [63:0] nominal_of();
		if (rate_den == 0)
			return 0;
		return rate_num / rate_den +
			(((rate_num % rate_den) >= ((rate_den + 1) / 2)) ? 64'd1 : 64'd0);
	endfunction

	function automatic tcc_pkg::out_word_t convert_timecode(tcc_pkg::in_word_t w);
		tcc_pkg::out_word_t r;
		logic [63:0] nom, dpm, per_day, lab, fpm, fph, fpm_d, fp10, rem;
		logic [63:0] h, m, s, f, tm, c;
		logic [3:0]  st;
		r = '0;
		nom = nominal_of();
		dpm = nom / 15;
		st = tcc_pkg::ST_OK;
		if (nom == 0)
			st = tcc_pkg::ST_BAD_RATE;
		else if (drop_on && !(rate_den == 1001 && (rate_num == 30000 || rate_num == 60000)))
			st = tcc_pkg::ST_BAD_DROP;
		if (st == tcc_pkg::ST_OK && w.op == 1'b0) begin
			per_day = nom * 86400;
			if (drop_on)
				per_day -= dpm * 1296;
			if (64'(w.frame_idx) >= per_day) begin
				st = tcc_pkg::ST_CNT_RANGE;
			end else begin
				lab = 64'(w.frame_idx);
				fpm = nom * 60;
				fph = nom * 3600;
				if (drop_on) begin
					fpm_d = fpm - dpm;
					fp10 = fpm * 10 - dpm * 9;
					rem = 64'(w.frame_idx) % fp10;
					lab += dpm * 9 * (64'(w.frame_idx) / fp10);
					if (rem > dpm)
						lab += dpm * ((rem - dpm) / fpm_d);
				end
				h = lab / fph; lab = lab % fph;
				m = lab / fpm; lab = lab % fpm;
				s = lab / nom;
				f = lab % nom;
				r.out_hours = h[4:0];
				r.out_minutes = m[5:0];
				r.out_seconds = s[5:0];
				r.out_frames = f[19:0];
			end
		end else if (st == tcc_pkg::ST_OK) begin
			h = 64'(w.hours); m = 64'(w.minutes); s = 64'(w.seconds); f = 64'(w.frames);
			if (h >= 24) st = tcc_pkg::ST_HOUR_RANGE;
			else if (m >= 60) st = tcc_pkg::ST_MIN_RANGE;
			else if (s >= 60) st = tcc_pkg::ST_SEC_RANGE;
			else if (f >= nom) st = tcc_pkg::ST_FRM_RANGE;
			else if (drop_on && (m % 10) != 0 && s == 0 && f < dpm) st = tcc_pkg::ST_DROPPED;
			if (st == tcc_pkg::ST_OK) begin
				tm = h * 60 + m;
				c = (tm * 60 + s) * nom + f;
				if (drop_on)
					c -= dpm * (tm - tm / 10);
				r.out_frame_count = c[36:0];
			end
		end
		r.status = st;
		return r;
	endfunction

	// Leaves cfg_valid high; the caller drops it after its last write.
	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tcc_pkg::REG_RATE_NUM: rate_num = 64'(val);
			tcc_pkg::REG_RATE_DEN: rate_den = 64'(val);
			default:               drop_on = val[0];
		endcase
	endtask

	task automatic apply_rate(rate_set_t rs);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		write_reg(tcc_pkg::REG_RATE_NUM, rs.num);
		write_reg(tcc_pkg::REG_RATE_DEN, rs.den);
		write_reg(tcc_pkg::REG_DROP, {19'd0, rs.drop});
		cfg_valid <= 1'b0;
	endtask

	// Records the expectation when the word is taken; a typed-in value wins.
	task automatic send_word(tcc_pkg::in_word_t w, logic known, tcc_pkg::out_word_t want);
		int gap;
		gap = short_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		pending_words.insert(pending_words.size(), known ? want : convert_timecode(w));
	endtask

	function automatic tcc_pkg::in_word_t random_word();
		tcc_pkg::in_word_t w;
		logic [63:0]       nom, per_day;
		nom = nominal_of();
		per_day = nom * 86400 - (drop_on ? (nom / 15) * 1296 : 0);
		w = IN_W'({$urandom, $urandom, $urandom});
		if ($urandom_range(0, 9) < 8) begin
			// Mostly well-formed words so that real conversions dominate.
			if (w.op == 1'b0 && per_day != 0) begin
				w.frame_idx = ($urandom_range(0, 7) == 0) ? 37'(per_day - 1)
					: 37'({$urandom, $urandom} % per_day);
			end else if (nom != 0) begin
				w.hours = 7'($urandom_range(0, 23));
				w.minutes = 7'($urandom_range(0, 59));
				w.seconds = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 59));
				w.frames = 20'({$urandom} % nom);
			end
		end
		return w;
	endfunction

	// Receiver: ready most of the time, with stalls of random length.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					rx_hold <= short_gap();
			end
		end
	end

	always @(posedge clk) begin
		tcc_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", out_data);
			end else begin
				want = pending_words.pop_front();
				if (out_data.status !== want.status
						|| out_data.out_hours !== want.out_hours
						|| out_data.out_minutes !== want.out_minutes
						|| out_data.out_seconds !== want.out_seconds
						|| out_data.out_frames !== want.out_frames
						|| out_data.out_frame_count !== want.out_frame_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t          rows[$];
		stim_row_t          row;
		rate_set_t          rates[$];
		tcc_pkg::in_word_t  w;
		tcc_pkg::out_word_t z;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		z = '0;

		// Directed table at the reset rate, non-drop.
		w = '0;
		row.word = w; row.known = 1; row.want = z; rows.insert(rows.size(), row);
		w.frame_idx = '1;
		row.word = w; row.want = z; row.want.status = tcc_pkg::ST_CNT_RANGE;
		rows.insert(rows.size(), row);
		w = '0; w.op = 1'b1; w.hours = 7'h7f;
		row.word = w; row.want = z; row.want.status = tcc_pkg::ST_HOUR_RANGE;
		rows.insert(rows.size(), row);
		w.hours = 7'd23; w.minutes = 7'h7f;
		row.word = w; row.want.status = tcc_pkg::ST_MIN_RANGE; rows.insert(rows.size(), row);
		w.minutes = 7'd59; w.seconds = 7'h7f;
		row.word = w; row.want.status = tcc_pkg::ST_SEC_RANGE; rows.insert(rows.size(), row);
		w.seconds = 7'd59; w.frames = '1;
		row.word = w; row.want.status = tcc_pkg::ST_FRM_RANGE; rows.insert(rows.size(), row);
		w.frames = 20'd29;
		row.word = w; row.known = 0; rows.insert(rows.size(), row);
		w = '0; w.op = 1'b1;
		row.word = w; row.known = 1; row.want = z; rows.insert(rows.size(), row);
		w = '0; w.frame_idx = 37'd2591999;
		row.word = w; row.known = 0; rows.insert(rows.size(), row);
		w.frame_idx = 37'd2592000;
		row.word = w; row.known = 1; row.want = z; row.want.status = tcc_pkg::ST_CNT_RANGE;
		rows.insert(rows.size(), row);
		foreach (rows[i])
			send_word(rows[i].word, rows[i].known, rows[i].want);

		// Drop-frame at 29.97: dropped label, minute boundaries, day end.
		apply_rate('{20'd30000, 20'd1001, 1'b1});
		w = '0; w.op = 1'b1; w.minutes = 7'd1; w.frames = 20'd1;
		send_word(w, 1, '{status: tcc_pkg::ST_DROPPED, default: '0});
		w.frames = 20'd2;
		send_word(w, 0, z);
		w.minutes = 7'd10; w.frames = 20'd0;
		send_word(w, 0, z);
		w = '0;
		w.frame_idx = 37'd1799; send_word(w, 0, z);
		w.frame_idx = 37'd1800; send_word(w, 0, z);
		w.frame_idx = 37'd17981; send_word(w, 0, z);
		w.frame_idx = 37'd17982; send_word(w, 0, z);
		w.frame_idx = 37'd2589407; send_word(w, 0, z);
		w.frame_idx = 37'd2589408; send_word(w, 0, z);

		// Bad rates: zero denominator, drop at a wrong rate and a rate that rounds to zero.
		apply_rate('{20'd25, 20'd0, 1'b0});
		send_word('0, 1, '{status: tcc_pkg::ST_BAD_RATE, default: '0});
		apply_rate('{20'd25, 20'd1, 1'b1});
		send_word('0, 1, '{status: tcc_pkg::ST_BAD_DROP, default: '0});
		apply_rate('{20'd1, 20'd1048575, 1'b0});
		send_word('0, 1, '{status: tcc_pkg::ST_BAD_RATE, default: '0});

		// Random phases over a spread of rate settings, extremes included.
		rates = '{
			'{20'd30000, 20'd1001, 1'b0}, '{20'd60000, 20'd1001, 1'b1},
			'{20'd25, 20'd1, 1'b0}, '{20'd24000, 20'd1001, 1'b0},
			'{20'd1048575, 20'd1, 1'b0}, '{20'd1, 20'd1, 1'b0},
			'{20'd1048575, 20'd1048574, 1'b0}, '{20'd3, 20'd2, 1'b0},
			'{20'd30000, 20'd1001, 1'b1}, '{20'd60000, 20'd1001, 1'b0},
			'{20'd50, 20'd1, 1'b1}, '{20'd1048575, 20'd1048575, 1'b1}};
		foreach (rates[k]) begin
			apply_rate(rates[k]);
			for (int n = 0; n < 128; n++)
				send_word(random_word(), 0, z);
		end

		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
